>>> rtl/core/arpre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpre_pkg
// Types, codes and sizes shared by the ARP resolution engine modules.
// ----------------------------------------------------------------------------
package arpre_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int PENDING_SLOTS = 8;
  localparam int QUEUE_DEPTH   = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int QCAP = (QUEUE_DEPTH < MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS;

  localparam int CIDX_W = $clog2(CACHE_ENTRIES);
  localparam int SIDX_W = $clog2(PENDING_SLOTS);
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QCAP + 1);
  localparam int QMEM_DEPTH = PENDING_SLOTS * QUEUE_DEPTH;

  localparam logic [15:0] LIFETIME_RESET = 16'd30000;
  localparam logic [15:0] HOLD_RESET     = 16'd5000;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ETH_ARP   = 16'h0806;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQ    = 16'd1;
  localparam logic [15:0] OP_REPLY  = 16'd2;

  localparam logic [1:0] CMD_SEND   = 2'd0;
  localparam logic [1:0] CMD_FRAME  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [1:0] CFG_OWN_IP   = 2'd1;
  localparam logic [1:0] CFG_LIFETIME = 2'd2;
  localparam logic [1:0] CFG_HOLD     = 2'd3;

  localparam logic [2:0] KIND_FRAME   = 3'd0;
  localparam logic [2:0] KIND_REQ     = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_DELIVER = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  typedef enum logic [2:0] {
    SEL_HIT, SEL_REQ, SEL_REPLY, SEL_DELIVER, SEL_DROP, SEL_FLUSH
  } arpre_sel_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] hop_ip;
    logic [15:0] handle;
    logic [47:0] frame_dst_mac;
    logic [15:0] ethertype;
    logic [15:0] arp_opcode;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_target_ip;
    logic [15:0] elapsed_ms;
  } arpre_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] dst_mac;
    logic [31:0] arp_target_ip_res;
    logic [47:0] arp_target_mac;
    logic [15:0] out_handle;
    logic        last;
  } arpre_res_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    arpre_sel_e sel;
    logic       last;
    logic       q_push;
    logic       slot_alloc;
    logic       slot_free;
    logic       learn_wr;
    logic       evict_start;
    logic       evict_step;
    logic       flush_first;
    logic       flush_next;
    logic       age_all;
    logic       expire;
  } arpre_ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       cache_hit;
    logic       cache_free;
    logic       slot_hit;
    logic       slot_avail;
    logic       q_full;
    logic       for_us;
    logic       is_arp;
    logic       is_ipv4;
    logic       req_own;
    logic       is_reply;
    logic       cnt_zero;
    logic       evict_last;
    logic       flush_last;
  } arpre_stat_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

>>> rtl/core/arp_resolution_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_resolution_engine_core
// ARP resolver for one interface: IP to MAC cache, pending requests with
// queued datagram handles, request replies and IPv4 delivery.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                       Payload
// item      in         start_i & !busy_o               item_i (arpre_item_t)
// result    out        result_valid_o, one cycle each  result_o (arpre_res_t)
// config    in         cfg_we_i                        cfg_idx_i, cfg_data_i
//
// A send only executes; a tick adds an expiry step; an ARP frame adds a response
// step, the oldest-entry scan when the cache is full and the sender is new, and
// one step per flushed handle. Each result appears in the cycle after its step;
// flushed handles come on consecutive cycles, one per cycle, from queue memory.
// Reset clears all valid bits and queue counts at once; no clearing pass.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module arp_resolution_engine_core
  import arpre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  arpre_item_t item_i,
  output arpre_res_t  result_o,
  output logic        result_valid_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  arpre_ctrl_t ctrl;
  arpre_stat_t stat;

  arpre_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  arpre_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

>>> rtl/core/arpre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpre_ctrl
// Sequencer of the ARP engine: decodes the item and steps the datapath.
// ----------------------------------------------------------------------------
module arpre_ctrl
  import arpre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  arpre_stat_t stat_i,
  output arpre_ctrl_t ctrl_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_EVICT = 3'd2;
  localparam logic [2:0] ST_EVWR  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;
  localparam logic [2:0] ST_TICK2 = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (stat_i.cmd)
          CMD_SEND: begin
            if (stat_i.cache_hit) begin
              ctrl_o.emit = 1'b1;
              ctrl_o.sel  = SEL_HIT;
              ctrl_o.last = 1'b1;
            end else if (stat_i.slot_hit) begin
              if (!stat_i.q_full) begin
                ctrl_o.q_push = 1'b1;
              end else begin
                ctrl_o.emit = 1'b1;
                ctrl_o.sel  = SEL_DROP;
                ctrl_o.last = 1'b1;
              end
            end else if (stat_i.slot_avail) begin
              ctrl_o.slot_alloc = 1'b1;
              ctrl_o.emit       = 1'b1;
              ctrl_o.sel        = SEL_REQ;
              ctrl_o.last       = 1'b1;
            end else begin
              ctrl_o.emit = 1'b1;
              ctrl_o.sel  = SEL_DROP;
              ctrl_o.last = 1'b1;
            end
          end
          CMD_FRAME: begin
            if (stat_i.for_us && stat_i.is_arp) begin
              if (stat_i.cache_hit || stat_i.cache_free) begin
                ctrl_o.learn_wr = 1'b1;
                state_d         = ST_RESP;
              end else begin
                ctrl_o.evict_start = 1'b1;
                state_d            = ST_EVICT;
              end
            end else if (stat_i.for_us && stat_i.is_ipv4) begin
              ctrl_o.emit = 1'b1;
              ctrl_o.sel  = SEL_DELIVER;
              ctrl_o.last = 1'b1;
            end
          end
          CMD_TICK: begin
            ctrl_o.age_all = 1'b1;
            state_d        = ST_TICK2;
          end
          default: ;
        endcase
      end
      ST_EVICT: begin
        ctrl_o.evict_step = 1'b1;
        if (stat_i.evict_last) begin
          state_d = ST_EVWR;
        end
      end
      ST_EVWR: begin
        ctrl_o.learn_wr = 1'b1;
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
        if (stat_i.req_own) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.sel  = SEL_REPLY;
          ctrl_o.last = 1'b1;
        end else if (stat_i.is_reply && stat_i.slot_hit) begin
          if (stat_i.cnt_zero) begin
            ctrl_o.slot_free = 1'b1;
          end else begin
            ctrl_o.flush_first = 1'b1;
            state_d            = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.sel  = SEL_FLUSH;
        ctrl_o.last = stat_i.flush_last;
        if (stat_i.flush_last) begin
          ctrl_o.slot_free = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          ctrl_o.flush_next = 1'b1;
        end
      end
      ST_TICK2: begin
        ctrl_o.expire = 1'b1;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/arpre_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpre_dp
// Datapath of the ARP engine: cache, pending slots, handle queue memory,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module arpre_dp
  import arpre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  arpre_item_t item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  arpre_ctrl_t ctrl_i,
  output arpre_stat_t stat_o,
  output arpre_res_t  result_o,
  output logic        result_valid_o
);

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  logic [15:0] lifetime_q, hold_q;

  arpre_item_t item_q;

  logic [CACHE_ENTRIES-1:0] cache_valid_q;
  logic [31:0] cache_ip_q  [CACHE_ENTRIES];
  logic [47:0] cache_mac_q [CACHE_ENTRIES];
  logic [15:0] cache_age_q [CACHE_ENTRIES];

  logic [PENDING_SLOTS-1:0] slot_valid_q;
  logic [31:0]      slot_ip_q    [PENDING_SLOTS];
  logic [15:0]      slot_age_q   [PENDING_SLOTS];
  logic [CNT_W-1:0] slot_count_q [PENDING_SLOTS];

  logic [15:0] qmem [QMEM_DEPTH];
  logic [15:0] q_rdata_q;

  logic [CIDX_W-1:0] ev_cnt_q, best_idx_q;
  logic [15:0]       best_age_q;
  logic [QIDX_W-1:0] fl_k_q;

  arpre_res_t res_q, res_d;
  logic       res_valid_q;

  logic [31:0]       key;
  logic              cache_hit, cache_free, slot_hit, slot_avail;
  logic [CIDX_W-1:0] hit_idx, free_idx, learn_idx;
  logic [SIDX_W-1:0] slot_idx, free_slot;
  logic [15:0]       cand_age;
  logic [CNT_W-1:0]  cur_cnt;
  logic              q_we, q_re;
  logic [SIDX_W+QIDX_W-1:0] q_waddr, q_raddr;
  logic [CACHE_ENTRIES-1:0] cache_exp;
  logic [PENDING_SLOTS-1:0] slot_clr, slot_exp;

  // Sends look up the next hop, ARP frames the sender address.
  assign key = (item_q.cmd == CMD_SEND) ? item_q.hop_ip : item_q.arp_sender_ip;

  always_comb begin
    cache_hit  = 1'b0;
    cache_free = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (cache_valid_q[i] && cache_ip_q[i] == key) begin
        cache_hit = 1'b1;
        hit_idx   = CIDX_W'(i);
      end
      if (!cache_valid_q[i]) begin
        cache_free = 1'b1;
        free_idx   = CIDX_W'(i);
      end
    end
  end

  always_comb begin
    slot_hit   = 1'b0;
    slot_avail = 1'b0;
    slot_idx   = '0;
    free_slot  = '0;
    for (int j = PENDING_SLOTS - 1; j >= 0; j--) begin
      if (slot_valid_q[j] && slot_ip_q[j] == key) begin
        slot_hit = 1'b1;
        slot_idx = SIDX_W'(j);
      end
      if (!slot_valid_q[j]) begin
        slot_avail = 1'b1;
        free_slot  = SIDX_W'(j);
      end
    end
  end

  assign cur_cnt   = slot_count_q[slot_idx];
  assign cand_age  = cache_age_q[ev_cnt_q];
  assign learn_idx = cache_hit ? hit_idx : (cache_free ? free_idx : best_idx_q);

  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      cache_exp[i] = cache_valid_q[i] && (cache_age_q[i] >= lifetime_q);
    end
    for (int j = 0; j < PENDING_SLOTS; j++) begin
      slot_exp[j] = slot_valid_q[j] && (slot_age_q[j] >= hold_q);
      slot_clr[j] = 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (cache_exp[i] && cache_ip_q[i] == slot_ip_q[j] && slot_valid_q[j]) begin
          slot_clr[j] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat_o.cmd        = item_q.cmd;
    stat_o.cache_hit  = cache_hit;
    stat_o.cache_free = cache_free;
    stat_o.slot_hit   = slot_hit;
    stat_o.slot_avail = slot_avail;
    stat_o.q_full     = (cur_cnt >= CNT_W'(QCAP));
    stat_o.for_us     = (item_q.frame_dst_mac == own_mac_q) ||
                        (item_q.frame_dst_mac == BCAST_MAC);
    stat_o.is_arp     = (item_q.ethertype == ETH_ARP);
    stat_o.is_ipv4    = (item_q.ethertype == ETH_IPV4);
    stat_o.req_own    = (item_q.arp_opcode == OP_REQ) &&
                        (item_q.arp_target_ip == own_ip_q);
    stat_o.is_reply   = (item_q.arp_opcode == OP_REPLY);
    stat_o.cnt_zero   = (cur_cnt == '0);
    stat_o.evict_last = (ev_cnt_q == CIDX_W'(CACHE_ENTRIES - 1));
    stat_o.flush_last = ((CNT_W'(fl_k_q) + CNT_W'(1)) == cur_cnt);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q  <= '0;
      own_ip_q   <= '0;
      lifetime_q <= LIFETIME_RESET;
      hold_q     <= HOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_MAC:  own_mac_q  <= cfg_data_i;
        CFG_OWN_IP:   own_ip_q   <= cfg_data_i[31:0];
        CFG_LIFETIME: lifetime_q <= cfg_data_i[15:0];
        CFG_HOLD:     hold_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q <= item_i;
    end
  end

  // Cache valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_valid_q <= '0;
    end else if (ctrl_i.learn_wr) begin
      cache_valid_q[learn_idx] <= 1'b1;
    end else if (ctrl_i.expire) begin
      cache_valid_q <= cache_valid_q & ~cache_exp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.learn_wr) begin
      cache_ip_q[learn_idx]  <= item_q.arp_sender_ip;
      cache_mac_q[learn_idx] <= item_q.arp_sender_mac;
      cache_age_q[learn_idx] <= '0;
    end else if (ctrl_i.age_all) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (cache_valid_q[i]) begin
          cache_age_q[i] <= sat_add(cache_age_q[i], item_q.elapsed_ms);
        end
      end
    end
  end

  // Oldest-entry scan, one entry per cycle; ties keep the lower index.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.evict_start) begin
      ev_cnt_q   <= CIDX_W'(1);
      best_idx_q <= '0;
      best_age_q <= cache_age_q[0];
    end else if (ctrl_i.evict_step) begin
      ev_cnt_q <= ev_cnt_q + CIDX_W'(1);
      if (cand_age > best_age_q) begin
        best_idx_q <= ev_cnt_q;
        best_age_q <= cand_age;
      end
    end
  end

  // Pending slot control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      for (int j = 0; j < PENDING_SLOTS; j++) begin
        slot_count_q[j] <= '0;
      end
    end else begin
      if (ctrl_i.slot_alloc) begin
        slot_valid_q[free_slot] <= 1'b1;
        slot_count_q[free_slot] <= CNT_W'(1);
      end
      if (ctrl_i.q_push) begin
        slot_count_q[slot_idx] <= cur_cnt + CNT_W'(1);
      end
      if (ctrl_i.slot_free) begin
        slot_valid_q[slot_idx] <= 1'b0;
        slot_count_q[slot_idx] <= '0;
      end
      if (ctrl_i.expire) begin
        for (int j = 0; j < PENDING_SLOTS; j++) begin
          if (slot_clr[j] || slot_exp[j]) begin
            slot_count_q[j] <= '0;
          end
          if (slot_exp[j]) begin
            slot_valid_q[j] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.slot_alloc) begin
      slot_ip_q[free_slot]  <= item_q.hop_ip;
      slot_age_q[free_slot] <= '0;
    end else if (ctrl_i.age_all) begin
      for (int j = 0; j < PENDING_SLOTS; j++) begin
        if (slot_valid_q[j]) begin
          slot_age_q[j] <= sat_add(slot_age_q[j], item_q.elapsed_ms);
        end
      end
    end
  end

  // Handle queue memory: one row of QUEUE_DEPTH entries per slot.
  assign q_we    = ctrl_i.q_push || ctrl_i.slot_alloc;
  assign q_waddr = ctrl_i.q_push ? {slot_idx, cur_cnt[QIDX_W-1:0]} : {free_slot, QIDX_W'(0)};
  assign q_re    = ctrl_i.flush_first || ctrl_i.flush_next;
  assign q_raddr = {slot_idx, ctrl_i.flush_first ? QIDX_W'(0) : (fl_k_q + QIDX_W'(1))};

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[q_waddr] <= item_q.handle;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_re) begin
      q_rdata_q <= qmem[q_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.flush_first) begin
      fl_k_q <= '0;
    end else if (ctrl_i.flush_next) begin
      fl_k_q <= fl_k_q + QIDX_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctrl_i.emit;
    end
  end

  always_comb begin
    res_d      = '0;
    res_d.last = ctrl_i.last;
    case (ctrl_i.sel)
      SEL_HIT: begin
        res_d.kind       = KIND_FRAME;
        res_d.dst_mac    = cache_mac_q[hit_idx];
        res_d.out_handle = item_q.handle;
      end
      SEL_REQ: begin
        res_d.kind              = KIND_REQ;
        res_d.dst_mac           = BCAST_MAC;
        res_d.arp_target_ip_res = item_q.hop_ip;
      end
      SEL_REPLY: begin
        res_d.kind              = KIND_REPLY;
        res_d.dst_mac           = item_q.arp_sender_mac;
        res_d.arp_target_ip_res = item_q.arp_sender_ip;
        res_d.arp_target_mac    = item_q.arp_sender_mac;
      end
      SEL_DELIVER: begin
        res_d.kind       = KIND_DELIVER;
        res_d.out_handle = item_q.handle;
      end
      SEL_DROP: begin
        res_d.kind       = KIND_DROP;
        res_d.out_handle = item_q.handle;
      end
      SEL_FLUSH: begin
        res_d.kind       = KIND_FRAME;
        res_d.dst_mac    = item_q.arp_sender_mac;
        res_d.out_handle = q_rdata_q;
      end
      default: res_d.kind = KIND_DROP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      res_q <= res_d;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule

>>> rtl/core/arpre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpre_checker
// Port-level checks of the ARP engine, bound to the top level.
// ----------------------------------------------------------------------------
module arpre_checker
  import arpre_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input arpre_res_t  result_o,
  input logic        result_valid_o
);

  // An accepted item always leaves the engine busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("engine not busy after accepting an item");

  // Results of one item come back to back until the last one.
  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o)
    else $error("gap inside the results of one item");

  // A result is only produced while an item was being worked on.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without an item in progress");

  // ARP requests go to the broadcast address.
  a_request_bcast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.kind == KIND_REQ |-> result_o.dst_mac == BCAST_MAC)
    else $error("ARP request not broadcast");

endmodule

bind arp_resolution_engine_core arpre_checker u_arpre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_o       (result_o),
  .result_valid_o (result_valid_o)
);

>>> tb/tb_arp_resolution_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_resolution_engine_core
// Self-checking bench for the ARP resolver: it runs directed and random send,
// frame and tick items, keeps its own cache and pending-slot state, and
// compares every result field by field against the predicted result stream.
// ----------------------------------------------------------------------------
module tb_arp_resolution_engine_core;
  import arpre_pkg::*;

  class arp_scoreboard;
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [15:0] lifetime;
    logic [15:0] hold;
    logic        c_vld[CACHE_ENTRIES];
    logic [31:0] c_ip[CACHE_ENTRIES];
    logic [47:0] c_mac[CACHE_ENTRIES];
    logic [15:0] c_age[CACHE_ENTRIES];
    logic        s_vld[PENDING_SLOTS];
    logic [31:0] s_ip[PENDING_SLOTS];
    logic [15:0] s_age[PENDING_SLOTS];
    int          s_cnt[PENDING_SLOTS];
    logic [15:0] s_q[PENDING_SLOTS][QUEUE_DEPTH];
    arpre_res_t  pending_res[$];
    int          n_errors;
    int          n_results;
    int          n_flushes;
    int          n_drops;

    function new();
      own_mac = '0;
      own_ip = '0;
      lifetime = LIFETIME_RESET;
      hold = HOLD_RESET;
      n_errors = 0;
      n_results = 0;
      n_flushes = 0;
      n_drops = 0;
      for (int i = 0; i < CACHE_ENTRIES; i++) c_vld[i] = 1'b0;
      for (int i = 0; i < PENDING_SLOTS; i++) begin
        s_vld[i] = 1'b0;
        s_cnt[i] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [47:0] val);
      case (idx)
        CFG_OWN_MAC:  own_mac = val;
        CFG_OWN_IP:   own_ip = val[31:0];
        CFG_LIFETIME: lifetime = val[15:0];
        default:      hold = val[15:0];
      endcase
    endfunction

    function int cache_lookup(logic [31:0] ip);
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (c_vld[i] && c_ip[i] == ip) return i;
      return -1;
    endfunction

    function int slot_lookup(logic [31:0] ip);
      for (int i = 0; i < PENDING_SLOTS; i++)
        if (s_vld[i] && s_ip[i] == ip) return i;
      return -1;
    endfunction

    function logic [15:0] age_sum(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function void push_res(logic [2:0] k, logic [47:0] dm, logic [31:0] tip,
                           logic [47:0] tm, logic [15:0] h);
      arpre_res_t r;
      r.kind = k;
      r.dst_mac = dm;
      r.arp_target_ip_res = tip;
      r.arp_target_mac = tm;
      r.out_handle = h;
      r.last = 1'b0;
      pending_res.push_back(r);
      if (k == KIND_DROP) n_drops++;
    endfunction

    function void learn_mapping(logic [31:0] ip, logic [47:0] mac);
      int e;
      e = cache_lookup(ip);
      if (e < 0)
        for (int i = 0; i < CACHE_ENTRIES; i++)
          if (!c_vld[i]) begin
            e = i;
            break;
          end
      if (e < 0) begin
        e = 0;
        for (int i = 1; i < CACHE_ENTRIES; i++)
          if (c_age[i] > c_age[e]) e = i;
      end
      c_vld[e] = 1'b1;
      c_ip[e] = ip;
      c_mac[e] = mac;
      c_age[e] = '0;
    endfunction

    // Works out the results of one accepted item and updates the state.
    function void note_item(arpre_item_t it);
      int before_n;
      int e;
      int s;
      before_n = pending_res.size();
      case (it.cmd)
        CMD_SEND: begin
          e = cache_lookup(it.hop_ip);
          if (e >= 0) push_res(KIND_FRAME, c_mac[e], '0, '0, it.handle);
          else begin
            s = slot_lookup(it.hop_ip);
            if (s >= 0) begin
              if (s_cnt[s] < QCAP) begin
                s_q[s][s_cnt[s]] = it.handle;
                s_cnt[s]++;
              end else push_res(KIND_DROP, '0, '0, '0, it.handle);
            end else begin
              for (int i = 0; i < PENDING_SLOTS; i++)
                if (!s_vld[i]) begin
                  s = i;
                  break;
                end
              if (s < 0) push_res(KIND_DROP, '0, '0, '0, it.handle);
              else begin
                s_vld[s] = 1'b1;
                s_ip[s] = it.hop_ip;
                s_age[s] = '0;
                s_q[s][0] = it.handle;
                s_cnt[s] = 1;
                push_res(KIND_REQ, BCAST_MAC, it.hop_ip, '0, '0);
              end
            end
          end
        end
        CMD_FRAME: begin
          if (it.frame_dst_mac == own_mac || it.frame_dst_mac == BCAST_MAC) begin
            if (it.ethertype == ETH_ARP) begin
              learn_mapping(it.arp_sender_ip, it.arp_sender_mac);
              if (it.arp_opcode == OP_REQ && it.arp_target_ip == own_ip)
                push_res(KIND_REPLY, it.arp_sender_mac, it.arp_sender_ip,
                         it.arp_sender_mac, '0);
              else if (it.arp_opcode == OP_REPLY) begin
                s = slot_lookup(it.arp_sender_ip);
                if (s >= 0) begin
                  for (int k = 0; k < s_cnt[s]; k++)
                    push_res(KIND_FRAME, it.arp_sender_mac, '0, '0, s_q[s][k]);
                  if (s_cnt[s] > 0) n_flushes++;
                  s_vld[s] = 1'b0;
                  s_cnt[s] = 0;
                end
              end
            end else if (it.ethertype == ETH_IPV4)
              push_res(KIND_DELIVER, '0, '0, '0, it.handle);
          end
        end
        CMD_TICK: begin
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (!c_vld[i]) continue;
            c_age[i] = age_sum(c_age[i], it.elapsed_ms);
            if (c_age[i] >= lifetime) begin
              s = slot_lookup(c_ip[i]);
              c_vld[i] = 1'b0;
              if (s >= 0) s_cnt[s] = 0;
            end
          end
          for (int i = 0; i < PENDING_SLOTS; i++) begin
            if (!s_vld[i]) continue;
            s_age[i] = age_sum(s_age[i], it.elapsed_ms);
            if (s_age[i] >= hold) begin
              s_vld[i] = 1'b0;
              s_cnt[i] = 0;
            end
          end
        end
        default: ;
      endcase
      if (pending_res.size() > before_n)
        pending_res[pending_res.size() - 1].last = 1'b1;
    endfunction

    function void check_result(arpre_res_t got);
      arpre_res_t exp_r;
      n_results++;
      if (pending_res.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp_r = pending_res.pop_front();
      if (got !== exp_r) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: result mismatch\n  expected %p\n  actual   %p", exp_r, got);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  arpre_item_t item_i;
  arpre_res_t  result_o;
  logic        result_valid_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [47:0] cfg_data_i;

  arp_scoreboard sb;
  int            idle_cycles = 0;
  int            n_items;
  logic [31:0]   ip_pool[12];
  logic [47:0]   mac_pool[12];

  arp_resolution_engine_core i_dut (.*);

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start_i && !busy_o) sb.note_item(item_i);
      if ((start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Stalled after %0d items with %0d results outstanding.",
                 n_items, sb.pending_res.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Start stays high into a following item that has no idle gap; any other
  // caller drops it before waiting.
  task automatic send_item(arpre_item_t it);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_i <= it;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    n_items++;
  endtask

  // Holds the sender off until every predicted result has come out.
  task automatic wait_results();
    start_i <= 1'b0;
    while (sb.pending_res.size() != 0) @(negedge clk_i);
  endtask

  // Waits until all predicted results are out and the block has gone quiet.
  task automatic drain();
    wait_results();
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [47:0] val);
    drain();
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic arpre_item_t noise_item();
    arpre_item_t it;
    logic [287:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(arpre_item_t)-1:0];
    return it;
  endfunction

  function automatic arpre_item_t mk_send(logic [31:0] ip, logic [15:0] h);
    arpre_item_t it;
    it = noise_item();
    it.cmd = CMD_SEND;
    it.hop_ip = ip;
    it.handle = h;
    return it;
  endfunction

  function automatic arpre_item_t mk_arp(logic [47:0] dst, logic [15:0] op,
                                         logic [31:0] sip, logic [47:0] smac,
                                         logic [31:0] tip);
    arpre_item_t it;
    it = noise_item();
    it.cmd = CMD_FRAME;
    it.frame_dst_mac = dst;
    it.ethertype = ETH_ARP;
    it.arp_opcode = op;
    it.arp_sender_ip = sip;
    it.arp_sender_mac = smac;
    it.arp_target_ip = tip;
    return it;
  endfunction

  function automatic arpre_item_t mk_tick(logic [15:0] ms);
    arpre_item_t it;
    it = noise_item();
    it.cmd = CMD_TICK;
    it.elapsed_ms = ms;
    return it;
  endfunction

  function automatic logic [47:0] pick_dst();
    case ($urandom_range(0, 5))
      0:       return 48'({$urandom, $urandom});
      1, 2:    return BCAST_MAC;
      default: return sb.own_mac;
    endcase
  endfunction

  function automatic arpre_item_t random_item();
    arpre_item_t it;
    int j;
    j = $urandom_range(0, 11);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: it = mk_send(ip_pool[j], 16'($urandom));
      7, 8, 9: it = mk_arp(pick_dst(), OP_REPLY, ip_pool[j], mac_pool[j], $urandom);
      10, 11: it = mk_arp(pick_dst(), OP_REQ, ip_pool[j], mac_pool[j],
                          ($urandom_range(0, 1) != 0) ? sb.own_ip : ip_pool[j]);
      12: it = mk_arp(pick_dst(), 16'($urandom), {$urandom},
                      48'({$urandom, $urandom}), $urandom);
      13, 14: begin
        it = noise_item();
        it.cmd = CMD_FRAME;
        it.frame_dst_mac = pick_dst();
        if ($urandom_range(0, 2) != 0) it.ethertype = ETH_IPV4;
      end
      15, 16: it = mk_tick(($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 400))
                                                         : 16'($urandom));
      17: it = mk_send($urandom, 16'($urandom));
      default: it = noise_item();
    endcase
    return it;
  endfunction

  initial begin
    sb = new();
    n_items = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OWN_MAC;
    cfg_data_i = '0;
    for (int i = 0; i < 12; i++) begin
      ip_pool[i] = {$urandom};
      mac_pool[i] = 48'({$urandom, $urandom});
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part with reset settings first, then the configured address.
    send_item(mk_send(32'h0, 16'h0));
    send_item(mk_send(32'hFFFF_FFFF, 16'hFFFF));
    send_item(mk_arp(48'h0, OP_REQ, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0));
    write_cfg(CFG_OWN_MAC, 48'h0200_0000_0001);
    write_cfg(CFG_OWN_IP, 32'hC0A8_0001);
    send_item(mk_arp(48'h0, OP_REQ, 32'h1, 48'h1, 32'hC0A8_0001));
    send_item(mk_arp(BCAST_MAC, OP_REPLY, 32'hFFFF_FFFF, 48'hAB, 32'h0));
    send_item(mk_send(32'hFFFF_FFFF, 16'h1234));
    for (int k = 0; k < 9; k++) send_item(mk_send(32'h0A00_0009, 16'(k)));
    send_item(mk_arp(48'h0200_0000_0001, OP_REPLY, 32'h0A00_0009, 48'h77, 32'h0));
    send_item(mk_arp(48'h0200_0000_0001, 16'hFFFF, 32'h5, 48'h5, 32'h0));
    send_item(mk_arp(48'h1234, OP_REQ, 32'h6, 48'h6, 32'hC0A8_0001));
    begin
      arpre_item_t it;
      it = noise_item();
      it.cmd = CMD_FRAME;
      it.frame_dst_mac = BCAST_MAC;
      it.ethertype = ETH_IPV4;
      send_item(it);
      it.cmd = CMD_UNUSED;
      send_item(it);
    end
    for (int k = 0; k < 9; k++) send_item(mk_send(32'h0B00_0000 + k, 16'(k)));
    for (int k = 0; k < 17; k++)
      send_item(mk_arp(BCAST_MAC, OP_REQ, 32'h0C00_0000 + k, 48'(k), 32'h0));
    send_item(mk_tick(16'hFFFF));
    send_item(mk_tick(16'h0));

    // Random phases across several timer settings, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_cfg(CFG_LIFETIME, 48'd1);
          write_cfg(CFG_HOLD, 48'd1);
        end
        1: begin
          write_cfg(CFG_LIFETIME, 48'd65535);
          write_cfg(CFG_HOLD, 48'd65535);
          write_cfg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        end
        2: begin
          write_cfg(CFG_LIFETIME, 48'd0);
          write_cfg(CFG_HOLD, 48'd0);
          write_cfg(CFG_OWN_IP, 48'hFFFF_FFFF);
        end
        default: begin
          write_cfg(CFG_LIFETIME, 48'($urandom_range(200, 3000)));
          write_cfg(CFG_HOLD, 48'($urandom_range(100, 1500)));
          write_cfg(CFG_OWN_MAC, 48'({$urandom, $urandom}));
          write_cfg(CFG_OWN_IP, 48'(ip_pool[$urandom_range(0, 11)]));
        end
      endcase
      for (int k = 0; k < 50; k++) begin
        send_item(random_item());
        // The sender holds off now and then until all results are out.
        if (k % 20 == 19) wait_results();
      end
    end

    drain();
    $display("Covered %0d items: %0d results, %0d queue flushes, %0d drops.",
             n_items, sb.n_results, sb.n_flushes, sb.n_drops);
    if (sb.n_errors == 0 && sb.pending_res.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
